// ===== rtl/gbp_pkg.sv =====
package gbp_pkg;

  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_MAX_COLS    = 64;
  localparam int DEF_HEIGHT_BITS = 20;
  localparam int DIM_W           = 7;
  localparam int CFG_IDX_W       = 1;
  localparam int OUT_W           = 20;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_CLEAR,
    ST_SEED,
    ST_POP,
    ST_CUR,
    ST_NBR,
    ST_CHECK,
    ST_FIN,
    ST_DECIDE,
    ST_OUT
  } gbp_state_t;

  typedef struct packed {
    logic load_wr;
    logic load_clr;
    logic search_init;
    logic clear_step;
    logic seed;
    logic pop;
    logic cur_rd;
    logic nbr_rd;
    logic nbr_check;
    logic fin_rd;
    logic decide;
  } gbp_cmd_t;

  typedef struct packed {
    logic last_cell;
    logic clear_done;
    logic queue_empty;
    logic nbr_last;
    logic search_done;
  } gbp_sts_t;

endpackage

// ===== rtl/gbp_stream_if.sv =====
interface gbp_stream_if #(
  parameter int W = 20
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/gbp_cfg_if.sv =====
interface gbp_cfg_if #(
  parameter int IW = 1,
  parameter int DW = 7
);
  logic          valid;
  logic          ready;
  logic [IW-1:0] index;
  logic [DW-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/gbp_ctrl.sv =====
module gbp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_taken,
  input  gbp_pkg::gbp_sts_t sts,
  output gbp_pkg::gbp_cmd_t cmd,
  output logic              in_rdy,
  output logic              out_vld
);
  import gbp_pkg::*;

  gbp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_LOAD;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_rdy    = 1'b0;
    out_vld   = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          cmd.load_wr = 1'b1;
          if (sts.last_cell) state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.search_init = 1'b1;
        state_nxt = ST_CLEAR;
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_nxt = ST_SEED;
      end
      ST_SEED: begin
        cmd.seed  = 1'b1;
        state_nxt = ST_POP;
      end
      ST_POP: begin
        if (sts.queue_empty) begin
          cmd.fin_rd = 1'b1;
          state_nxt  = ST_FIN;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = ST_CUR;
        end
      end
      ST_CUR: begin
        cmd.cur_rd = 1'b1;
        state_nxt  = ST_NBR;
      end
      ST_NBR: begin
        cmd.nbr_rd = 1'b1;
        state_nxt  = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.nbr_check = 1'b1;
        state_nxt = sts.nbr_last ? ST_POP : ST_NBR;
      end
      ST_FIN: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.search_done ? ST_OUT : ST_CLEAR;
      end
      ST_OUT: begin
        out_vld = 1'b1;
        if (out_taken) begin
          cmd.load_clr = 1'b1;
          state_nxt    = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  ap_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> !in_rdy) else $error("result and load overlap");
  ap_load_goes_init: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && sts.last_cell) |=> state_r == ST_INIT)
    else $error("search did not start");
  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && !out_taken) |=> out_vld) else $error("result dropped");
endmodule

// ===== rtl/gbp_dp.sv =====
module gbp_dp #(
  parameter int MAX_ROWS    = gbp_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = gbp_pkg::DEF_MAX_COLS,
  parameter int HEIGHT_BITS = gbp_pkg::DEF_HEIGHT_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gbp_pkg::gbp_cmd_t        cmd,
  output gbp_pkg::gbp_sts_t        sts,
  input  logic                     cfg_we,
  input  logic [gbp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [gbp_pkg::DIM_W-1:0] cfg_val,
  input  logic [gbp_pkg::OUT_W-1:0] in_height,
  output logic [gbp_pkg::OUT_W-1:0] out_effort
);
  import gbp_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int KW    = $clog2(MAX_COLS + 1);
  localparam int QW    = RW + KW + AW;
  localparam int HB    = HEIGHT_BITS;
  localparam logic [HB:0] HMAX = {1'b0, {HB{1'b1}}};

  logic [HB-1:0] height_mem [CELLS];
  logic          visited_mem [CELLS];
  // queue entry: {row, col, address}
  logic [QW-1:0] queue_mem [CELLS];

  logic [RW-1:0] rows_r;
  logic [KW-1:0] cols_r;
  logic [CW-1:0] loaded_r;
  logic [CW-1:0] total;
  logic [HB:0]   low_r, high_r, mid_r;
  logic [HB-1:0] best_r;
  logic [CW-1:0] head_r, tail_r;
  logic [AW-1:0] clr_r;
  logic [AW-1:0] cell_r;
  logic [RW-1:0] row_r;
  logic [KW-1:0] col_r;
  logic [1:0]    dir_r;
  logic [HB-1:0] cur_h_r, nbr_h_r;
  logic          nbr_vis_r, nbr_ok_r;
  logic [AW-1:0] nbr_r;
  logic [RW-1:0] nbr_row_r;
  logic [KW-1:0] nbr_col_r;
  logic [QW-1:0] q_rd_r;
  logic          fin_vis_r;

  function automatic logic [RW-1:0] clamp_r(input logic [DIM_W-1:0] v);
    if (v == '0) return RW'(1);
    if (32'(v) > MAX_ROWS) return RW'(MAX_ROWS);
    return RW'(v);
  endfunction

  function automatic logic [KW-1:0] clamp_c(input logic [DIM_W-1:0] v);
    if (v == '0) return KW'(1);
    if (32'(v) > MAX_COLS) return KW'(MAX_COLS);
    return KW'(v);
  endfunction

  assign total = CW'(rows_r) * CW'(cols_r);

  // neighbour of cell_r in direction dir_r: right, left, down, up
  logic          n_ok;
  logic [AW-1:0] n_addr;
  logic [RW-1:0] n_row;
  logic [KW-1:0] n_col;
  always_comb begin
    n_ok   = 1'b0;
    n_addr = cell_r;
    n_row  = row_r;
    n_col  = col_r;
    case (dir_r)
      2'd0: begin
        n_ok   = (KW+1)'(col_r) + 1'b1 < (KW+1)'(cols_r);
        n_addr = cell_r + AW'(1);
        n_col  = col_r + 1'b1;
      end
      2'd1: begin
        n_ok   = col_r != '0;
        n_addr = cell_r - AW'(1);
        n_col  = col_r - 1'b1;
      end
      2'd2: begin
        n_ok   = (RW+1)'(row_r) + 1'b1 < (RW+1)'(rows_r);
        n_addr = cell_r + AW'(cols_r);
        n_row  = row_r + 1'b1;
      end
      default: begin
        n_ok   = row_r != '0;
        n_addr = cell_r - AW'(cols_r);
        n_row  = row_r - 1'b1;
      end
    endcase
  end

  logic [HB-1:0] diff;
  assign diff = (cur_h_r > nbr_h_r) ? cur_h_r - nbr_h_r : nbr_h_r - cur_h_r;
  logic push;
  assign push = cmd.nbr_check && nbr_ok_r && !nbr_vis_r && ({1'b0, diff} <= mid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= RW'(1);
      cols_r   <= KW'(1);
      loaded_r <= '0;
      low_r    <= '0;
      high_r   <= '0;
      best_r   <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_GRID_ROWS) rows_r <= clamp_r(cfg_val);
        else                          cols_r <= clamp_c(cfg_val);
        loaded_r <= '0;
      end
      if (cmd.load_wr) loaded_r <= sts.last_cell ? '0 : loaded_r + 1'b1;
      if (cmd.load_clr) loaded_r <= '0;
      if (cmd.search_init) begin
        low_r  <= '0;
        high_r <= HMAX;
        best_r <= '0;
        mid_r  <= HMAX >> 1;
      end
      if (cmd.decide) begin
        if (fin_vis_r) begin
          best_r <= mid_r[HB-1:0];
          high_r <= mid_r - 1'b1;
          mid_r  <= low_r + ((mid_r - 1'b1 - low_r) >> 1);
        end else begin
          low_r <= mid_r + 1'b1;
          mid_r <= mid_r + 1'b1 + ((high_r - mid_r - 1'b1) >> 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) height_mem[loaded_r[AW-1:0]] <= HB'(in_height);
    if (cmd.search_init || cmd.decide) clr_r <= '0;
    if (cmd.clear_step) begin
      visited_mem[clr_r] <= 1'b0;
      clr_r <= clr_r + 1'b1;
    end
    if (cmd.seed) begin
      visited_mem[0] <= 1'b1;
      queue_mem[0]   <= '0;
      head_r <= '0;
      tail_r <= CW'(1);
    end
    if (cmd.pop) begin
      q_rd_r <= queue_mem[head_r[AW-1:0]];
      head_r <= head_r + 1'b1;
    end
    if (cmd.cur_rd) begin
      cell_r  <= q_rd_r[AW-1:0];
      row_r   <= q_rd_r[AW+KW +: RW];
      col_r   <= q_rd_r[AW +: KW];
      cur_h_r <= height_mem[q_rd_r[AW-1:0]];
      dir_r   <= '0;
    end
    if (cmd.nbr_rd) begin
      nbr_r     <= n_addr;
      nbr_row_r <= n_row;
      nbr_col_r <= n_col;
      nbr_ok_r  <= n_ok;
      nbr_h_r   <= height_mem[n_addr];
      nbr_vis_r <= visited_mem[n_addr];
    end
    if (cmd.nbr_check) dir_r <= dir_r + 1'b1;
    if (push) begin
      visited_mem[nbr_r] <= 1'b1;
      queue_mem[tail_r[AW-1:0]] <= {nbr_row_r, nbr_col_r, nbr_r};
      tail_r <= tail_r + 1'b1;
    end
    if (cmd.fin_rd) fin_vis_r <= visited_mem[AW'(total - 1'b1)];
  end

  assign sts.last_cell   = (loaded_r + 1'b1) >= total;
  assign sts.clear_done  = clr_r == AW'(CELLS - 1);
  assign sts.queue_empty = head_r == tail_r;
  assign sts.nbr_last    = dir_r == 2'd3;
  // decided from the probe in hand, so the last probe ends the search at once
  assign sts.search_done = fin_vis_r ? (mid_r == '0 || mid_r - 1'b1 < low_r)
                                     : (mid_r + 1'b1 > high_r);
  assign out_effort      = OUT_W'(best_r);

  ap_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> head_r < tail_r) else $error("queue underrun");
  ap_mid_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decide |-> mid_r <= HMAX) else $error("probe out of range");
  ap_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.nbr_check |-> tail_r <= total) else $error("queue overrun");
endmodule

// ===== rtl/grid_bottleneck_path_bsearch_flood.sv =====
// Loads a grid of grid_rows x grid_cols heights in row-major order, one beat per
// cycle, then binary-searches the smallest step threshold joining the top-left and
// bottom-right cells, one breadth-first flood per probe, and returns it as one beat.
// Each probe clears the whole visited map (all MAX_ROWS*MAX_COLS entries) then visits
// each reached cell using its single-port height and visited memories;
// there are HEIGHT_BITS+1 probes at most. Input is not ready during the search.
// A configuration write restarts the load.
module grid_bottleneck_path_bsearch_flood #(
  parameter int MAX_ROWS    = gbp_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = gbp_pkg::DEF_MAX_COLS,
  parameter int HEIGHT_BITS = gbp_pkg::DEF_HEIGHT_BITS
) (
  input logic clk,
  input logic rst_n,
  gbp_stream_if.sink   in_ch,
  gbp_stream_if.source out_ch,
  gbp_cfg_if.sink      cfg_ch
);
  import gbp_pkg::*;

  gbp_cmd_t cmd;
  gbp_sts_t sts;
  logic     in_rdy, out_vld;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_rdy;
  assign out_ch.valid = out_vld;

  gbp_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire   (in_ch.valid && in_rdy),
    .out_taken (out_ch.ready),
    .sts, .cmd, .in_rdy, .out_vld
  );

  gbp_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .HEIGHT_BITS(HEIGHT_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .cfg_we    (cfg_ch.valid),
    .cfg_idx   (cfg_ch.index),
    .cfg_val   (cfg_ch.wdata),
    .in_height (in_ch.data),
    .out_effort(out_ch.data)
  );
endmodule

// ===== bench/testbench.sv =====
module testbench;
  import gbp_pkg::*;

  localparam int MAX_CELLS   = DEF_MAX_ROWS * DEF_MAX_COLS;
  localparam int CYCLE_LIMIT = 250_000_000;

  logic clk;
  logic rst_n;

  gbp_stream_if #(.W(DEF_HEIGHT_BITS)) in_ch ();
  gbp_stream_if #(.W(OUT_W))           out_ch ();
  gbp_cfg_if #(.IW(CFG_IDX_W), .DW(DIM_W)) cfg_ch ();

  grid_bottleneck_path_bsearch_flood dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state
  logic [19:0] grid_h [MAX_CELLS];
  bit          seen [MAX_CELLS];
  int          flood_q [MAX_CELLS];
  int          pred_rows, pred_cols, cells_in;
  logic [19:0] effort_q [$];
  int          errors = 0;
  int          cycles = 0;
  int          items_sent;
  int          stall_left;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int clamp_dim(logic [DIM_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function bit corner_reachable(int rows, int cols, int thr);
    int head, tail, cur, r, c, nb, k;
    int dr [4];
    int dc [4];
    dr = '{0, 0, 1, -1};
    dc = '{1, -1, 0, 0};
    for (int i = 0; i < rows * cols; i++) seen[i] = 1'b0;
    head = 0;
    tail = 1;
    seen[0] = 1'b1;
    flood_q[0] = 0;
    while (head < tail) begin
      cur = flood_q[head];
      head++;
      r = cur / cols;
      c = cur % cols;
      for (k = 0; k < 4; k++) begin
        if (r + dr[k] < 0 || r + dr[k] >= rows || c + dc[k] < 0 || c + dc[k] >= cols)
          continue;
        nb = cur + dr[k] * cols + dc[k];
        if (seen[nb]) continue;
        if ((grid_h[cur] > grid_h[nb] ? grid_h[cur] - grid_h[nb]
                                      : grid_h[nb] - grid_h[cur]) > thr)
          continue;
        seen[nb] = 1'b1;
        flood_q[tail] = nb;
        tail++;
      end
    end
    return seen[rows * cols - 1];
  endfunction

  function logic [19:0] search_min_effort(int rows, int cols);
    int lo, hi, mid, best;
    lo = 0;
    hi = (1 << DEF_HEIGHT_BITS) - 1;
    best = 0;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (corner_reachable(rows, cols, mid)) begin
        best = mid;
        if (mid == 0) break;
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return best[19:0];
  endfunction

  function void accept_cell(logic [19:0] h);
    int total;
    total = pred_rows * pred_cols;
    if (cells_in >= total) cells_in = 0;
    grid_h[cells_in] = h;
    cells_in++;
    if (cells_in == total) begin
      cells_in = 0;
      effort_q.push_back(search_min_effort(pred_rows, pred_cols));
    end
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_cell(logic [19:0] h);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= h;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    accept_cell(h);
    items_sent++;
  endtask

  // let the block drain before touching its registers
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (effort_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_GRID_ROWS) pred_rows = clamp_dim(v, DEF_MAX_ROWS);
    else pred_cols = clamp_dim(v, DEF_MAX_COLS);
    cells_in = 0;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(logic [DIM_W-1:0] r, logic [DIM_W-1:0] c);
    settle();
    write_reg(REG_GRID_ROWS, r);
    write_reg(REG_GRID_COLS, c);
  endtask

  task automatic send_grid(int mode);
    logic [19:0] base;
    base = 20'($urandom_range(0, (1 << DEF_HEIGHT_BITS) - 1));
    for (int i = 0; i < pred_rows * pred_cols; i++) begin
      case (mode)
        0: send_cell(20'($urandom_range(0, (1 << DEF_HEIGHT_BITS) - 1)));
        1: send_cell(20'(base + $urandom_range(0, 15)));
        default: send_cell($urandom_range(0, 1) ? 20'hFFFFF : 20'h0);
      endcase
    end
  endtask

  task automatic test_reset_size();
    // one-cell grid after reset
    send_cell(20'($urandom_range(0, (1 << DEF_HEIGHT_BITS) - 1)));
    send_cell(20'hFFFFF);
  endtask

  task automatic test_extreme_heights();
    set_grid(7'd1, 7'd2);
    send_cell(20'h0);
    send_cell(20'hFFFFF);
    send_cell(20'hFFFFF);
    send_cell(20'hFFFFF);
    send_cell(20'hFFFFF);
    send_cell(20'h0);
  endtask

  task automatic test_dim_clamp();
    set_grid(7'd0, 7'd127);
    send_grid(0);
    set_grid(7'd127, 7'd0);
    send_grid(2);
  endtask

  task automatic test_load_restart();
    set_grid(7'd3, 7'd3);
    for (int i = 0; i < 4; i++) send_cell(20'($urandom_range(0, 1000)));
    settle();
    write_reg(REG_GRID_COLS, 7'd4);
    send_grid(1);
  endtask

  task automatic test_random_grids();
    int r, c;
    while (items_sent < 700) begin
      r = $urandom_range(1, 8);
      c = $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0) r = 0;
      if ($urandom_range(0, 9) == 0) c = 0;
      if ($urandom_range(0, 2) != 0) set_grid(DIM_W'(r), DIM_W'(c));
      send_grid($urandom_range(0, 2));
    end
  endtask

  // result side: random back-pressure and checking
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 70) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(0, 3);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (effort_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none got %0d", $time, out_ch.data);
          errors++;
        end else begin
          if (out_ch.data !== effort_q[0]) begin
            $display("%0t: min_effort expected %0d got %0d", $time, effort_q[0],
                     out_ch.data);
            errors++;
          end
          void'(effort_q.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_GRID_ROWS;
    cfg_ch.wdata = '0;
    pred_rows    = 1;
    pred_cols    = 1;
    cells_in     = 0;
    items_sent   = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_size();
    test_extreme_heights();
    test_dim_clamp();
    test_load_restart();
    test_random_grids();
    settle();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== grid_bottleneck_path_bsearch_flood.f =====
rtl/gbp_pkg.sv
rtl/gbp_stream_if.sv
rtl/gbp_cfg_if.sv
rtl/gbp_ctrl.sv
rtl/gbp_dp.sv
rtl/grid_bottleneck_path_bsearch_flood.sv
bench/testbench.sv
